[rtl/core/flf_pkg.sv]
`timescale 1ns / 1ps

package flf_pkg;

    // Filter structure.
    localparam int STAGES     = 4;
    localparam int STAGE_W    = (STAGES > 1) ? $clog2(STAGES) : 1;

    // Tanh table: TANH_N + 1 entries covering [0, 4.0].
    localparam int TANH_LOG2  = 8;
    localparam int TANH_N     = 1 << TANH_LOG2;
    localparam int TANH_FRAC  = 25 - TANH_LOG2;

    // Field and datapath widths.
    localparam int SAMPLE_W   = 24;
    localparam int DW         = 40;
    localparam int AW         = 36;
    localparam int BW         = 28;
    localparam int PW         = 64;

    // Arithmetic constants.
    localparam logic [BW-1:0] COMP_SLOPE  = BW'(39322);
    localparam logic [BW-1:0] RECIP3      = BW'(178956971);
    localparam int            RECIP3_SH   = 29;
    localparam logic [35:0]   SAT_THRESH  = 36'd50331647;
    localparam logic signed [31:0] GUARD_LIMIT = 32'sd838860800;
    localparam logic signed [PW-1:0] OUT_MAX = 64'sd8388607;
    localparam logic signed [PW-1:0] OUT_MIN = -64'sd8388608;

    // Register reset values.
    localparam logic [15:0] RST_INTEGRATOR_GAIN   = 16'd2048;
    localparam logic [15:0] RST_RESONANCE_K       = 16'd0;
    localparam logic [15:0] RST_SLEW_COEFFICIENT  = 16'd45350;
    localparam logic [15:0] RST_INPUT_ATTENUATION = 16'd32768;
    localparam logic [23:0] RST_OUTPUT_SCALE      = 24'd131072;
    localparam logic [15:0] RST_FEEDBACK_DIVIDER  = 16'd32768;
    localparam logic [15:0] RST_OTA_GAIN          = 16'd29491;
    localparam logic [29:0] RST_CLIP_LEVEL        = 30'd50331648;

    // Register indexes.
    typedef enum logic [2:0] {
        REG_INTEGRATOR_GAIN   = 3'd0,
        REG_RESONANCE_K       = 3'd1,
        REG_SLEW_COEFFICIENT  = 3'd2,
        REG_INPUT_ATTENUATION = 3'd3,
        REG_OUTPUT_SCALE      = 3'd4,
        REG_FEEDBACK_DIVIDER  = 3'd5,
        REG_OTA_GAIN          = 3'd6,
        REG_CLIP_LEVEL        = 3'd7
    } t_reg;

    // Datapath operations, each one pass through the shared multiplier.
    typedef enum logic [3:0] {
        OP_COMP,
        OP_ATT1,
        OP_ATT2,
        OP_FB,
        OP_KFB,
        OP_DIV3,
        OP_INTERP,
        OP_CELL,
        OP_GAIN,
        OP_SLEW,
        OP_OUT
    } t_op;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic               load;
        logic               mul;
        logic               wb;
        t_op                op;
        logic [STAGE_W-1:0] stage;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_stall;
    } t_stat;

    typedef logic [23:0] t_tanh_tab [0:TANH_N];

    // Shift-subtract division, used only while building the table.
    function automatic logic [63:0] f_udiv(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // tanh(4j/N) in Q.23 via exp(-2x) from a series on x/8, squared four times.
    function automatic t_tanh_tab f_build_tanh();
        t_tanh_tab         tab;
        logic [63:0]       z;
        logic [63:0]       term;
        logic signed [63:0] e;
        logic [63:0]       ue;
        logic [63:0]       den;
        logic [63:0]       num;
        for (int j = 0; j <= TANH_N; j++) begin
            z    = f_udiv((64'(j) << 30) + 64'(TANH_N), 64'(2 * TANH_N));
            term = 64'd1 << 30;
            e    = 64'sd1 <<< 30;
            for (int n = 1; n <= 16; n++) begin
                term = f_udiv((term * z) >> 30, 64'(n));
                if (n[0]) begin
                    e = e - $signed(term);
                end else begin
                    e = e + $signed(term);
                end
            end
            if (e < 0) begin
                e = '0;
            end
            ue = $unsigned(e);
            for (int r = 0; r < 4; r++) begin
                ue = (ue * ue + (64'd1 << 29)) >> 30;
            end
            den    = (64'd1 << 30) + ue;
            num    = ((64'd1 << 30) - ue) << 23;
            tab[j] = 24'(f_udiv(num + (den >> 1), den));
        end
        return tab;
    endfunction

    localparam t_tanh_tab TANH_TAB = f_build_tanh();

    // Right shift that rounds half away from zero.
    function automatic logic signed [PW-1:0] f_rnd(input logic signed [PW-1:0] v, input int s);
        return (v + (64'sd1 <<< (s - 1)) - $signed({63'd0, v[PW-1]})) >>> s;
    endfunction

    // Runaway state is dropped to zero.
    function automatic logic signed [31:0] f_guard(input logic signed [31:0] v);
        return (v >= GUARD_LIMIT || v <= -GUARD_LIMIT) ? 32'sd0 : v;
    endfunction

endpackage

[rtl/core/flf_if.sv]
`timescale 1ns / 1ps

// Input sample channel.
interface flf_in_if;
    import flf_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;
    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

// Output sample channel.
interface flf_out_if;
    import flf_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;
    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

// Register write channel.
interface flf_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [29:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/four_stage_saturating_ladder_filter.sv]
// Each sample makes 26 passes through the shared multiplier (five per stage plus six for
// input, feedback and output), each pass a multiply state and then a write-back state.
// A new sample is taken only once the last one's passes are done, as the multiplier is shared.
// A waiting result does not block the next sample; only its final write waits.
// Reset is synchronous and active low: filter state clears to zero and the
// registers take their default values.
`timescale 1ns / 1ps

module four_stage_saturating_ladder_filter
    import flf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    flf_in_if.sink     i_in,
    flf_out_if.source  o_out,
    flf_cfg_if.sink    i_cfg
);

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

    // Sequencer.
    flf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Arithmetic, state and registers.
    flf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_sample    (i_in.sample_in),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_sample    (o_out.sample_out)
    );

endmodule

[rtl/core/flf_ctrl.sv]
`timescale 1ns / 1ps

module flf_ctrl
    import flf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_WB
    } t_state;

    t_state             r_state;
    t_op                r_op;
    logic [STAGE_W-1:0] r_stage;
    logic               wb_go;

    // The final write-back waits while the output register is still full.
    assign wb_go = (r_state == ST_WB) && !((r_op == OP_OUT) && i_stat.out_stall);

    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_cmd.load   = (r_state == ST_IDLE) && i_in_valid;
    assign o_cmd.mul    = (r_state == ST_MUL);
    assign o_cmd.wb     = wb_go;
    assign o_cmd.op     = r_op;
    assign o_cmd.stage  = r_stage;

    // Operation sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= OP_COMP;
            r_stage <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_MUL;
                        r_op    <= OP_COMP;
                        r_stage <= '0;
                    end
                end
                ST_MUL: begin
                    r_state <= ST_WB;
                end
                ST_WB: begin
                    if (wb_go) begin
                        r_state <= (r_op == OP_OUT) ? ST_IDLE : ST_MUL;
                        unique case (r_op)
                            OP_COMP:   r_op <= OP_ATT1;
                            OP_ATT1:   r_op <= OP_ATT2;
                            OP_ATT2:   r_op <= OP_FB;
                            OP_FB:     r_op <= OP_KFB;
                            OP_KFB:    r_op <= OP_DIV3;
                            OP_DIV3:   r_op <= OP_INTERP;
                            OP_INTERP: r_op <= OP_CELL;
                            OP_CELL:   r_op <= OP_GAIN;
                            OP_GAIN:   r_op <= OP_SLEW;
                            OP_SLEW: begin
                                if (r_stage == STAGE_W'(STAGES - 1)) begin
                                    r_op <= OP_OUT;
                                end else begin
                                    r_op    <= OP_DIV3;
                                    r_stage <= r_stage + 1'b1;
                                end
                            end
                            OP_OUT:    r_op <= OP_COMP;
                            default:   r_op <= OP_COMP;
                        endcase
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // The result is never written over a waiting one.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.wb && o_cmd.op == OP_OUT) |-> !i_stat.out_stall)
        else $error("result written while output stalled");

    // A new sample always starts at the compensation step of the first stage.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (o_cmd.mul && o_cmd.op == OP_COMP && o_cmd.stage == '0))
        else $error("sample did not start at the first operation");

    // After the result is written the block is ready for the next sample.
    a_ready_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.wb && o_cmd.op == OP_OUT) |=> o_in_ready)
        else $error("not ready after result");

endmodule

[rtl/core/flf_dp.sv]
`timescale 1ns / 1ps

module flf_dp
    import flf_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    output t_stat                      o_stat,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_cfg_we,
    input  logic [2:0]                 i_cfg_index,
    input  logic [29:0]                i_cfg_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [SAMPLE_W-1:0] o_sample
);

    // Configuration registers.
    logic [15:0] r_g, r_k, r_coef, r_att, r_div, r_cell;
    logic [23:0] r_osc;
    logic [29:0] r_clip;

    // Filter state.
    logic signed [31:0] r_integ [STAGES];
    logic signed [31:0] r_slw   [STAGES];
    logic signed [31:0] r_last;

    // Working registers.
    logic signed [26:0]    r_x;
    logic [15:0]           r_comp;
    logic signed [DW-1:0]  r_acc, r_fb, r_cur, r_y;
    logic                  r_neg, r_sat;
    logic [24:0]           r_t;
    logic [23:0]           r_ta, r_tb, r_th;
    logic signed [27:0]    r_s;
    logic signed [PW-1:0]  r_prod;
    logic signed [SAMPLE_W-1:0] r_out;
    logic                  r_out_valid;

    logic signed [DW-1:0]  st, sl, diff, mag, clipv, sl_new, y_new, v_new;
    logic signed [AW-1:0]  a_op;
    logic [BW-1:0]         b_op;
    logic signed [BW:0]    b_s;
    logic signed [PW-1:0]  mul_p, fin;
    logic [24:0]           t_new;
    logic [TANH_LOG2:0]    idx;
    logic [23:0]           dlt;
    logic [PW-1:0]         s_raw;
    logic [25:0]           s_mag;

    assign st    = DW'(r_integ[i_cmd.stage]);
    assign sl    = DW'(r_slw[i_cmd.stage]);
    assign diff  = r_cur - st;
    assign mag   = diff[DW-1] ? -diff : diff;
    assign clipv = $signed({{(DW-30){1'b0}}, r_clip});
    assign dlt   = (r_tb > r_ta) ? (r_tb - r_ta) : 24'd0;

    // Operand selection for the shared multiplier.
    always_comb begin
        a_op = '0;
        b_op = '0;
        case (i_cmd.op)
            OP_COMP:   begin a_op = $signed({20'd0, r_k});    b_op = COMP_SLOPE; end
            OP_ATT1:   begin a_op = AW'(r_x);                 b_op = BW'(r_att); end
            OP_ATT2:   begin a_op = AW'(r_acc);               b_op = BW'(r_comp); end
            OP_FB:     begin a_op = AW'(r_last);              b_op = BW'(r_div); end
            OP_KFB:    begin a_op = AW'(r_fb);                b_op = BW'(r_k); end
            OP_DIV3:   begin a_op = $signed({9'd0, mag[25:0], 1'b1}); b_op = RECIP3; end
            OP_INTERP: begin a_op = $signed({12'd0, dlt});
                             b_op = BW'(r_t[TANH_FRAC-1:0]); end
            OP_CELL:   begin a_op = $signed({12'd0, r_th});   b_op = BW'(r_cell); end
            OP_GAIN:   begin a_op = AW'(r_s);                 b_op = BW'(r_g); end
            OP_SLEW:   begin a_op = AW'(r_y - sl);            b_op = BW'(r_coef); end
            OP_OUT:    begin a_op = AW'(r_cur);               b_op = BW'(r_osc); end
            default:   begin a_op = '0;                       b_op = '0; end
        endcase
    end

    assign b_s   = $signed({1'b0, b_op});
    assign mul_p = PW'(a_op) * PW'(b_s);

    // Write-back arithmetic.
    assign t_new  = r_prod[RECIP3_SH +: 25];
    assign idx    = {1'b0, t_new[24:TANH_FRAC]};
    assign s_raw  = ($unsigned(r_prod) * 64'd3 + 64'd32768) >> 16;
    assign s_mag  = s_raw[25:0];
    assign v_new  = DW'(f_rnd(r_prod, 16));
    assign y_new  = v_new + st;
    assign sl_new = sl + DW'(f_rnd(r_prod, 16));
    assign fin    = f_rnd(r_prod, 19);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g    <= RST_INTEGRATOR_GAIN;
            r_k    <= RST_RESONANCE_K;
            r_coef <= RST_SLEW_COEFFICIENT;
            r_att  <= RST_INPUT_ATTENUATION;
            r_osc  <= RST_OUTPUT_SCALE;
            r_div  <= RST_FEEDBACK_DIVIDER;
            r_cell <= RST_OTA_GAIN;
            r_clip <= RST_CLIP_LEVEL;
        end else if (i_cfg_we) begin
            unique case (t_reg'(i_cfg_index))
                REG_INTEGRATOR_GAIN:   r_g    <= i_cfg_data[15:0];
                REG_RESONANCE_K:       r_k    <= i_cfg_data[15:0];
                REG_SLEW_COEFFICIENT:  r_coef <= i_cfg_data[15:0];
                REG_INPUT_ATTENUATION: r_att  <= i_cfg_data[15:0];
                REG_OUTPUT_SCALE:      r_osc  <= i_cfg_data[23:0];
                REG_FEEDBACK_DIVIDER:  r_div  <= i_cfg_data[15:0];
                REG_OTA_GAIN:          r_cell <= i_cfg_data[15:0];
                REG_CLIP_LEVEL:        r_clip <= i_cfg_data;
                default:               r_g    <= r_g;
            endcase
        end
    end

    // Filter state and output flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < STAGES; i++) begin
                r_integ[i] <= '0;
                r_slw[i]   <= '0;
            end
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A new result takes the output register as the old one leaves.
            if (i_cmd.wb && i_cmd.op == OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.mul && i_cmd.op == OP_OUT) begin
                r_last <= f_guard(r_cur[31:0]);
            end
            if (i_cmd.wb) begin
                case (i_cmd.op)
                    OP_GAIN: r_integ[i_cmd.stage] <= f_guard(y_new[31:0] + v_new[31:0]);
                    OP_SLEW: r_slw[i_cmd.stage]   <= f_guard(sl_new[31:0]);
                    default: ;
                endcase
            end
        end
    end

    // Working registers: sample load, multiply, write-back.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= {i_sample, 3'b000};
        end
        if (i_cmd.mul) begin
            r_prod <= mul_p;
            if (i_cmd.op == OP_DIV3) begin
                r_neg <= diff[DW-1];
                r_sat <= ($unsigned(mag[35:0]) > SAT_THRESH) || (mag[DW-1:36] != '0);
            end
        end
        if (i_cmd.wb) begin
            case (i_cmd.op)
                OP_COMP: r_comp <= 16'd8192 + 16'(f_rnd(r_prod, 16));
                OP_ATT1: r_acc  <= DW'(f_rnd(r_prod, 16));
                OP_ATT2: r_acc  <= DW'(f_rnd(r_prod, 13));
                OP_FB:   r_fb   <= DW'(f_rnd(r_prod, 16));
                OP_KFB:  r_cur  <= r_acc - DW'(f_rnd(r_prod, 13));
                OP_DIV3: begin
                    r_t  <= t_new;
                    r_ta <= TANH_TAB[idx];
                    r_tb <= TANH_TAB[idx + 1'b1];
                end
                OP_INTERP: begin
                    if (r_sat) begin
                        r_th <= TANH_TAB[TANH_N];
                    end else begin
                        r_th <= r_ta + 24'((r_prod + (64'sd1 <<< (TANH_FRAC - 1)))
                                           >>> TANH_FRAC);
                    end
                end
                OP_CELL: r_s <= r_neg ? -$signed({2'b00, s_mag}) : $signed({2'b00, s_mag});
                OP_GAIN: r_y <= y_new;
                OP_SLEW: begin
                    if (sl_new > clipv) begin
                        r_cur <= clipv;
                    end else if (sl_new < -clipv) begin
                        r_cur <= -clipv;
                    end else begin
                        r_cur <= sl_new;
                    end
                end
                OP_OUT: begin
                    if (fin > OUT_MAX) begin
                        r_out <= SAMPLE_W'(OUT_MAX);
                    end else if (fin < OUT_MIN) begin
                        r_out <= SAMPLE_W'(OUT_MIN);
                    end else begin
                        r_out <= fin[SAMPLE_W-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_stat.out_stall = r_out_valid && !i_out_ready;
    assign o_out_valid      = r_out_valid;
    assign o_sample         = r_out;

endmodule

[tb/tb_four_stage_saturating_ladder_filter.sv]
`timescale 1ns / 1ps

// Bit-exact model of the ladder filter that keeps its own state and registers
// and holds the output samples that are still to come.
class ladder_scoreboard;
    localparam int SPAN_SHIFT = 25;
    localparam longint RUNAWAY = 64'sd838860800;

    longint tanh_rom [0:flf_pkg::TANH_N];
    longint gain_g, res_k, slew_c, atten, out_scale, fb_div, cell_g, clip_lvl;
    int     integ [flf_pkg::STAGES];
    int     slew [flf_pkg::STAGES];
    int     last_out;
    logic signed [23:0] pending_samples [$];

    function new();
        longint z, term, e, den, num;
        // The table holds tanh(4j/N) built from exp(-2x) in exact integers.
        for (int j = 0; j <= flf_pkg::TANH_N; j++) begin
            z    = ((longint'(j) << 30) + flf_pkg::TANH_N) / (2 * flf_pkg::TANH_N);
            term = 64'sd1 << 30;
            e    = 64'sd1 << 30;
            for (int n = 1; n <= 16; n++) begin
                term = ((term * z) >> 30) / n;
                if (n % 2 == 1) begin
                    e = e - term;
                end else begin
                    e = e + term;
                end
            end
            if (e < 0) begin
                e = 0;
            end
            for (int r = 0; r < 4; r++) begin
                e = (e * e + (64'sd1 << 29)) >> 30;
            end
            den = (64'sd1 << 30) + e;
            num = ((64'sd1 << 30) - e) << 23;
            tanh_rom[j] = (num + den / 2) / den;
        end
        gain_g    = longint'(flf_pkg::RST_INTEGRATOR_GAIN);
        res_k     = longint'(flf_pkg::RST_RESONANCE_K);
        slew_c    = longint'(flf_pkg::RST_SLEW_COEFFICIENT);
        atten     = longint'(flf_pkg::RST_INPUT_ATTENUATION);
        out_scale = longint'(flf_pkg::RST_OUTPUT_SCALE);
        fb_div    = longint'(flf_pkg::RST_FEEDBACK_DIVIDER);
        cell_g    = longint'(flf_pkg::RST_OTA_GAIN);
        clip_lvl  = longint'(flf_pkg::RST_CLIP_LEVEL);
        foreach (integ[i]) begin
            integ[i] = 0;
            slew[i]  = 0;
        end
        last_out = 0;
    endfunction

    // Shift right with rounding half away from zero.
    function longint shift_round(longint v, int s);
        longint half;
        half = 64'sd1 <<< (s - 1);
        if (v >= 0) begin
            return (v + half) >>> s;
        end
        return -((-v + half) >>> s);
    endfunction

    // Stage saturation: stage gain * 1.5 * tanh(diff / 1.5) in Q.23.
    function longint cell_saturate(longint diff);
        longint mag, t, pos, idx, th, frac, a, b, d, s;
        mag = (diff < 0) ? -diff : diff;
        t   = (mag * 2 + 1) / 3;
        pos = t * flf_pkg::TANH_N;
        idx = pos >> SPAN_SHIFT;
        if (idx >= flf_pkg::TANH_N) begin
            th = tanh_rom[flf_pkg::TANH_N];
        end else begin
            frac = pos & ((64'sd1 << SPAN_SHIFT) - 1);
            a    = tanh_rom[idx];
            b    = tanh_rom[idx + 1];
            d    = (b > a) ? b - a : 0;
            th   = a + ((d * frac + (64'sd1 << (SPAN_SHIFT - 1))) >> SPAN_SHIFT);
        end
        s = (th * cell_g * 3 + (64'sd1 << 15)) >> 16;
        return (diff < 0) ? -s : s;
    endfunction

    function int drop_runaway(int v);
        return (v >= RUNAWAY || v <= -RUNAWAY) ? 0 : v;
    endfunction

    function void set_reg(flf_pkg::t_reg idx, logic [29:0] value);
        case (idx)
            flf_pkg::REG_INTEGRATOR_GAIN:   gain_g    = longint'(value[15:0]);
            flf_pkg::REG_RESONANCE_K:       res_k     = longint'(value[15:0]);
            flf_pkg::REG_SLEW_COEFFICIENT:  slew_c    = longint'(value[15:0]);
            flf_pkg::REG_INPUT_ATTENUATION: atten     = longint'(value[15:0]);
            flf_pkg::REG_OUTPUT_SCALE:      out_scale = longint'(value[23:0]);
            flf_pkg::REG_FEEDBACK_DIVIDER:  fb_div    = longint'(value[15:0]);
            flf_pkg::REG_OTA_GAIN:          cell_g    = longint'(value[15:0]);
            flf_pkg::REG_CLIP_LEVEL:        clip_lvl  = longint'(value[29:0]);
            default: ;
        endcase
    endfunction

    // Run one accepted sample through the filter and queue its output.
    function void note_sample(logic signed [23:0] smp);
        longint x23, comp, att, fb, cur, st, v, y, sl, fin;
        x23  = longint'(smp) * 8;
        comp = 8192 + shift_round(res_k * 39322, 16);
        att  = shift_round(x23 * atten, 16);
        att  = shift_round(att * comp, 13);
        fb   = shift_round(longint'(last_out) * fb_div, 16);
        cur  = att - shift_round(res_k * fb, 13);
        for (int i = 0; i < flf_pkg::STAGES; i++) begin
            st       = integ[i];
            v        = shift_round(cell_saturate(cur - st) * gain_g, 16);
            y        = v + st;
            sl       = slew[i];
            integ[i] = int'(y + v);
            sl       = sl + shift_round(slew_c * (y - sl), 16);
            slew[i]  = int'(sl);
            // The clip acts on the full-width slew value.
            cur = (sl > clip_lvl) ? clip_lvl : ((sl < -clip_lvl) ? -clip_lvl : sl);
        end
        last_out = int'(cur);
        fin = shift_round(cur * out_scale, 19);
        if (fin > 8388607) begin
            fin = 8388607;
        end
        if (fin < -8388608) begin
            fin = -8388608;
        end
        for (int i = 0; i < flf_pkg::STAGES; i++) begin
            integ[i] = drop_runaway(integ[i]);
            slew[i]  = drop_runaway(slew[i]);
        end
        last_out = drop_runaway(last_out);
        pending_samples.push_back(fin[23:0]);
    endfunction

    // Compare a result with the oldest expectation.
    function bit check_sample(logic signed [23:0] got, output string why);
        logic signed [23:0] want;
        if (pending_samples.size() == 0) begin
            why = $sformatf("unexpected sample_out %0d", got);
            return 0;
        end
        want = pending_samples.pop_front();
        if (got !== want) begin
            why = $sformatf("sample_out %0d, want %0d", got, want);
            return 0;
        end
        return 1;
    endfunction

    function int outstanding();
        return pending_samples.size();
    endfunction
endclass

module tb_four_stage_saturating_ladder_filter;
    import flf_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE      = 70;

    logic i_clk;
    logic i_rst_n;

    flf_in_if  in_ch ();
    flf_out_if out_ch ();
    flf_cfg_if cfg_ch ();

    four_stage_saturating_ladder_filter uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    ladder_scoreboard filter_model;
    int  mismatches;
    int  cycles;
    bit  idle_on;
    int  hold_request;
    int  hold_served;
    int  hold_left;
    int  stall_left;

    // Clock.
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Cycle counter with a run limit.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic report(string why);
        mismatches++;
        $display("[%0t] mismatch: %s", $realtime, why);
    endtask

    // Output side: random stalls, plus a long hold-off when requested.
    always @(negedge i_clk) begin
        if (hold_request != hold_served) begin
            hold_served = hold_request;
            hold_left   = 400;
        end
        if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left--;
        end else if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 8) - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        string why;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (!filter_model.check_sample(out_ch.sample_out, why)) begin
                report(why);
            end
        end
    end

    // Offer one sample request and wait for it to be taken.
    task automatic send_sample(logic signed [23:0] smp);
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.sample_in <= smp;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        filter_model.note_sample(smp);
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
    endtask

    task automatic write_reg(t_reg idx, logic [29:0] value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        filter_model.set_reg(idx, value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Wait for every expected result, then for the pipeline to go quiet.
    task automatic drain();
        while (filter_model.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Write all eight registers: 0 random in range, 1 all low, 2 all high but for resonance
    // and clip level, 3 all at maximum, a setting that drives the state into runaway.
    task automatic program_regs(int mode);
        end_burst();
        drain();
        case (mode)
            1: begin
                write_reg(REG_INTEGRATOR_GAIN, 30'd0);
                write_reg(REG_RESONANCE_K, 30'd0);
                write_reg(REG_SLEW_COEFFICIENT, 30'd0);
                write_reg(REG_INPUT_ATTENUATION, 30'd0);
                write_reg(REG_OUTPUT_SCALE, 30'd0);
                write_reg(REG_FEEDBACK_DIVIDER, 30'd0);
                write_reg(REG_OTA_GAIN, 30'd0);
                write_reg(REG_CLIP_LEVEL, 30'd0);
            end
            2, 3: begin
                write_reg(REG_INTEGRATOR_GAIN, 30'd65535);
                write_reg(REG_RESONANCE_K, (mode == 3) ? 30'd65535 : 30'd32768);
                write_reg(REG_SLEW_COEFFICIENT, 30'd65535);
                write_reg(REG_INPUT_ATTENUATION, 30'd65535);
                write_reg(REG_OUTPUT_SCALE, 30'd16777215);
                write_reg(REG_FEEDBACK_DIVIDER, 30'd65535);
                write_reg(REG_OTA_GAIN, 30'd65535);
                write_reg(REG_CLIP_LEVEL, (mode == 3) ? 30'h3FFFFFFF : 30'd838860800);
            end
            default: begin
                write_reg(REG_INTEGRATOR_GAIN, 30'($urandom_range(256, 65535)));
                write_reg(REG_RESONANCE_K, 30'(($urandom_range(0, 7) == 0) ?
                          $urandom_range(32768, 65535) : $urandom_range(0, 32768)));
                write_reg(REG_SLEW_COEFFICIENT, 30'($urandom_range(0, 65535)));
                write_reg(REG_INPUT_ATTENUATION, 30'($urandom_range(0, 65535)));
                write_reg(REG_OUTPUT_SCALE, 30'($urandom_range(0, 16777215)));
                write_reg(REG_FEEDBACK_DIVIDER, 30'($urandom_range(0, 65535)));
                write_reg(REG_OTA_GAIN, 30'($urandom_range(0, 65535)));
                write_reg(REG_CLIP_LEVEL, 30'(($urandom_range(0, 7) == 0) ?
                          $urandom_range(838860800, 30'h3FFFFFFF) :
                          $urandom_range(0, 838860800)));
            end
        endcase
    endtask

    function automatic logic signed [23:0] random_sample();
        case ($urandom_range(0, 3))
            0: return 24'($urandom_range(0, 24'hFFFFFF));
            1: return 24'($signed($urandom_range(0, 8191)) - 4096);
            2: return $urandom_range(0, 1) ? 24'sh7FFFFF : -24'sh800000;
            default: return 24'($signed($urandom_range(0, 2097151)) - 1048576);
        endcase
    endfunction

    task automatic random_block(int count);
        for (int n = 0; n < count; n++) begin
            send_sample(random_sample());
        end
    endtask

    // Extremes of the sample, large swings past the table, and a DC step.
    task automatic directed_block();
        send_sample(24'sd0);
        send_sample(24'sh7FFFFF);
        send_sample(-24'sh800000);
        send_sample(24'sh7FFFFF);
        send_sample(-24'sd1);
        send_sample(24'sd1);
        send_sample(24'sh400000);
        send_sample(-24'sh400000);
        send_sample(24'sh555555);
        send_sample(-24'sh2AAAAB);
        for (int n = 0; n < 6; n++) begin
            send_sample(24'sh7FFFFF);
        end
    endtask

    initial begin
        filter_model = new();
        mismatches   = 0;
        cycles       = 0;
        idle_on      = 1'b1;
        hold_request = 0;
        hold_served  = 0;
        hold_left    = 0;
        stall_left   = 0;
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.sample_in  = '0;
        out_ch.ready     = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = REG_INTEGRATOR_GAIN;
        cfg_ch.data      = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part under the reset settings, then at the extremes.
        directed_block();
        program_regs(3);
        directed_block();
        program_regs(2);
        send_sample(24'sh7FFFFF);
        send_sample(-24'sh800000);
        program_regs(1);
        send_sample(24'sh7FFFFF);
        send_sample(-24'sh800000);

        // Random phases; the second one holds off the output for a long stretch.
        for (int ph = 0; ph < 8; ph++) begin
            program_regs((ph == 5) ? 3 : 0);
            if (ph == 1) begin
                hold_request++;
            end
            random_block(45);
            if (ph == 3) begin
                end_burst();
                drain();
            end
            random_block(45);
        end

        // Last stretch without any idling.
        program_regs(0);
        idle_on = 1'b0;
        random_block(80);
        end_burst();

        while (filter_model.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
